[design/trs_pkg.sv]
// Shared types, constants and helper functions of the vertex transform block.
package trs_pkg;

    // Fixed-point format of the matrix coefficients
    localparam int FRAC_BITS  = 16;
    // Shift from a Q30 rotation times a Q8.8 scale down to FRAC_BITS fraction bits
    localparam int COEF_SHIFT = 38 - FRAC_BITS;

    // CORDIC constants
    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

    // One full turn in 1/64 degree units
    localparam int TURN_UNITS = 23040;

    // Homogeneous w, 1.0 in Q16.16
    localparam logic [31:0] W_ONE = 32'h0001_0000;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_MOVE_X  = 3'd0,
        REG_MOVE_Y  = 3'd1,
        REG_MOVE_Z  = 3'd2,
        REG_PITCH   = 3'd3,
        REG_YAW     = 3'd4,
        REG_ROLL    = 3'd5,
        REG_SCALE   = 3'd6,
        REG_UNUSED  = 3'd7
    } t_reg_idx;

    // Configuration register file
    typedef struct packed {
        logic [2:0][31:0] move;   // x, y, z translation, Q16.16
        logic [2:0][15:0] angle;  // pitch, yaw, roll, 1/64 degree
        logic [47:0]      scale;  // x 47:32, y 31:16, z 15:0, Q8.8
    } t_cfg;

    // Nine matrix coefficients, row-major
    typedef logic [8:0][31:0] t_coefs;

    // Status handed from the matrix builder to the vertex pipeline
    typedef struct packed {
        logic   ready;
        t_coefs coef;
    } t_mat;

    // Phase of one turn unit remainder: a turn is 512 * 45 units, so with
    // r = 45q + m the rounded phase is q * 2^23 + floor((m * 2^23 + 22) / 45)
    function automatic logic [63:0][22:0] phase_table();
        logic [63:0][22:0] t;
        t = '0;
        for (int m = 0; m < 45; m++) begin
            t[m] = 23'((longint'(m) * 64'sd8388608 + 64'sd22) / 64'sd45);
        end
        return t;
    endfunction

    localparam logic [63:0][22:0] PHASE_TAB = phase_table();

    // Arctangent table in turn units (2^32 per turn)
    function automatic logic signed [31:0] atan_turn(input logic [4:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:  v = 32'sh20000000;
            5'd1:  v = 32'sh12E4051E;
            5'd2:  v = 32'sh09FB385B;
            5'd3:  v = 32'sh051111D4;
            5'd4:  v = 32'sh028B0D43;
            5'd5:  v = 32'sh0145D7E1;
            5'd6:  v = 32'sh00A2F61E;
            5'd7:  v = 32'sh00517C55;
            5'd8:  v = 32'sh0028BE53;
            5'd9:  v = 32'sh00145F2F;
            5'd10: v = 32'sh000A2F98;
            5'd11: v = 32'sh000517CC;
            5'd12: v = 32'sh00028BE6;
            5'd13: v = 32'sh000145F3;
            5'd14: v = 32'sh0000A2F9;
            5'd15: v = 32'sh0000517C;
            5'd16: v = 32'sh000028BE;
            5'd17: v = 32'sh0000145F;
            5'd18: v = 32'sh00000A2F;
            5'd19: v = 32'sh00000517;
            5'd20: v = 32'sh0000028B;
            5'd21: v = 32'sh00000145;
            5'd22: v = 32'sh000000A2;
            5'd23: v = 32'sh00000051;
            5'd24: v = 32'sh00000028;
            5'd25: v = 32'sh00000014;
            5'd26: v = 32'sh0000000A;
            5'd27: v = 32'sh00000005;
            5'd28: v = 32'sh00000002;
            5'd29: v = 32'sh00000001;
            default: v = 32'sh0;
        endcase
        return v;
    endfunction

    // Reduce a signed angle into one turn, [0, TURN_UNITS)
    function automatic logic [14:0] turn_reduce(input logic [15:0] ang);
        logic signed [16:0] a;
        logic signed [16:0] r;
        a = 17'(signed'(ang));
        if (a >= 17'sd23040) begin
            r = a - 17'sd23040;
        end else if (a < -17'sd23040) begin
            r = a + 17'sd46080;
        end else if (a < 17'sd0) begin
            r = a + 17'sd23040;
        end else begin
            r = a;
        end
        return r[14:0];
    endfunction

    // Saturate a wide signed value to signed 32 bits
    function automatic logic [31:0] sat32(input logic signed [65:0] v);
        logic [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Row-major index of a 3x3 entry
    function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
        return 4'(row) * 4'd3 + 4'(col);
    endfunction

    // Elements of the three rotation matrices, Q30
    function automatic logic signed [31:0] rx_elem(input logic [1:0] row,
                                                   input logic [1:0] col,
                                                   input logic signed [31:0] s,
                                                   input logic signed [31:0] c);
        logic signed [31:0] v;
        case ({row, col})
            4'b00_00: v = ONE_Q30;
            4'b01_01: v = c;
            4'b01_10: v = -s;
            4'b10_01: v = s;
            4'b10_10: v = c;
            default:  v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] ry_elem(input logic [1:0] row,
                                                   input logic [1:0] col,
                                                   input logic signed [31:0] s,
                                                   input logic signed [31:0] c);
        logic signed [31:0] v;
        case ({row, col})
            4'b00_00: v = c;
            4'b00_10: v = s;
            4'b01_01: v = ONE_Q30;
            4'b10_00: v = -s;
            4'b10_10: v = c;
            default:  v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] rz_elem(input logic [1:0] row,
                                                   input logic [1:0] col,
                                                   input logic signed [31:0] s,
                                                   input logic signed [31:0] c);
        logic signed [31:0] v;
        case ({row, col})
            4'b00_00: v = c;
            4'b00_01: v = -s;
            4'b01_00: v = s;
            4'b01_01: v = c;
            4'b10_10: v = ONE_Q30;
            default:  v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

[design/trs_infifo.sv]
// Input queue that decouples vertex acceptance from the transform pipeline.
module trs_infifo import trs_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_tvalid,
    output logic        o_tready,
    input  logic [95:0] i_tdata,
    output logic        o_vld,
    output logic [95:0] o_data,
    input  logic        i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [95:0]   r_mem [DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_tready = (r_cnt != CW'(DEPTH));
    assign o_vld    = (r_cnt != '0);
    assign o_data   = r_mem[r_rptr];
    assign push     = i_tvalid && o_tready;
    assign pop      = i_pop && o_vld;

    // Store each transfer at the write pointer
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_tdata;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/trs_mbuild.sv]
// Matrix builder: angle to phase, shared CORDIC, rotation products and scaling.
module trs_mbuild import trs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cfg_wr,
    output t_mat o_mat
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_CORD = 6'b000100,
        ST_MULA = 6'b001000,
        ST_MULR = 6'b010000,
        ST_COEF = 6'b100000
    } t_state;

    // Reciprocal of 45 for reduced angles below one turn: q = (r * 23302) >> 20
    localparam int PHASE_RECIP = 23302;

    t_state                  r_state;
    logic [1:0]              r_ang;
    logic [5:0]              r_cnt;
    logic [15:0]             r_rem;
    logic [8:0]              r_quo;
    logic signed [33:0]      r_x, r_y, r_z;
    logic                    r_neg;
    logic [2:0][31:0]        r_sin, r_cos;
    logic [31:0]             r_a   [9];
    logic [31:0]             r_rot [9];
    t_coefs                  r_coef;
    logic signed [63:0]      r_prod, r_acc;
    logic [1:0]              r_row, r_col, r_k;
    logic                    r_half;
    logic                    r_ready;

    logic [1:0]              ang_nx;
    logic [14:0]             red_nx;
    logic [29:0]             div_prod;
    logic [8:0]              div_q;
    logic [14:0]             div_m;
    logic [31:0]             phase;
    logic signed [33:0]      p_raw, p_fold;
    logic                    p_neg;
    logic signed [33:0]      xsh, ysh, atan34, x_nx, y_nx, z_nx;
    logic signed [31:0]      cos_fin, sin_fin;
    logic signed [31:0]      mul_a, mul_b;
    logic signed [63:0]      mul_p, acc_nx, rnd30;
    logic signed [63:0]      coef_sh;
    logic signed [15:0]      scale_c;
    logic                    last_entry;

    assign o_mat.ready = r_ready;
    assign o_mat.coef  = r_coef;

    // Next angle to start, reduced into one turn
    assign ang_nx = (r_state == ST_IDLE) ? 2'd0 : r_ang + 2'd1;
    assign red_nx = turn_reduce(i_cfg.angle[ang_nx]);

    // Split the reduced angle as 45q + m, then look up the phase of m
    assign div_prod = 30'(r_rem[14:0]) * 30'(PHASE_RECIP);
    assign div_q    = div_prod[28:20];
    assign div_m    = r_rem[14:0] - 15'(div_q) * 15'd45;
    assign phase    = {r_quo, 23'd0} + 32'(PHASE_TAB[r_rem[5:0]]);

    // Fold the phase into +-90 degrees
    always_comb begin
        p_raw  = 34'(signed'(phase));
        p_fold = p_raw;
        p_neg  = 1'b0;
        if (p_raw > 34'sh0_4000_0000) begin
            p_fold = p_raw - 34'sh0_8000_0000;
            p_neg  = 1'b1;
        end else if (p_raw < -34'sh0_4000_0000) begin
            p_fold = p_raw + 34'sh0_8000_0000;
            p_neg  = 1'b1;
        end
    end

    // One CORDIC rotation step
    always_comb begin
        xsh    = r_x >>> r_cnt[4:0];
        ysh    = r_y >>> r_cnt[4:0];
        atan34 = 34'(atan_turn(r_cnt[4:0]));
        if (r_z >= 34'sd0) begin
            x_nx = r_x - ysh;
            y_nx = r_y + xsh;
            z_nx = r_z - atan34;
        end else begin
            x_nx = r_x + ysh;
            y_nx = r_y - xsh;
            z_nx = r_z + atan34;
        end
        cos_fin = r_neg ? -x_nx[31:0] : x_nx[31:0];
        sin_fin = r_neg ? -y_nx[31:0] : y_nx[31:0];
    end

    // Select multiplier operands for the current entry
    always_comb begin
        case (r_col)
            2'd0:    scale_c = signed'(i_cfg.scale[47:32]);
            2'd1:    scale_c = signed'(i_cfg.scale[31:16]);
            default: scale_c = signed'(i_cfg.scale[15:0]);
        endcase
        mul_a = '0;
        mul_b = '0;
        if (r_state == ST_MULA) begin
            mul_a = rx_elem(r_row, r_k, signed'(r_sin[0]), signed'(r_cos[0]));
            mul_b = ry_elem(r_k, r_col, signed'(r_sin[1]), signed'(r_cos[1]));
        end else if (r_state == ST_MULR) begin
            mul_a = signed'(r_a[idx3(r_row, r_k)]);
            mul_b = rz_elem(r_k, r_col, signed'(r_sin[2]), signed'(r_cos[2]));
        end else if (r_state == ST_COEF) begin
            mul_a = signed'(r_rot[idx3(r_row, r_col)]);
            mul_b = 32'(scale_c);
        end
        mul_p      = mul_a * mul_b;
        acc_nx     = r_acc + r_prod;
        rnd30      = (acc_nx + 64'sd536870912) >>> 30;
        coef_sh    = (r_prod + (64'sd1 <<< (COEF_SHIFT - 1))) >>> COEF_SHIFT;
        last_entry = (r_row == 2'd2) && (r_col == 2'd2);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
            r_ang   <= '0;
            r_cnt   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
            r_half  <= 1'b0;
        end else if (i_cfg_wr) begin
            // Drop any build in progress and start over from idle
            r_state <= ST_IDLE;
            r_ready <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (!r_ready) begin
                        r_ang   <= 2'd0;
                        r_rem   <= {1'b0, red_nx};
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == '0) begin
                        // Hold quotient and remainder by 45
                        r_rem <= 16'(div_m);
                        r_quo <= div_q;
                        r_cnt <= 6'd1;
                    end else begin
                        r_z     <= p_fold;
                        r_neg   <= p_neg;
                        r_x     <= CORDIC_K;
                        r_y     <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    r_x <= x_nx;
                    r_y <= y_nx;
                    r_z <= z_nx;
                    if (r_cnt == 6'(CORDIC_STEPS - 1)) begin
                        r_sin[r_ang] <= sin_fin;
                        r_cos[r_ang] <= cos_fin;
                        r_cnt        <= '0;
                        if (r_ang == 2'd2) begin
                            r_row   <= '0;
                            r_col   <= '0;
                            r_k     <= '0;
                            r_half  <= 1'b0;
                            r_acc   <= '0;
                            r_state <= ST_MULA;
                        end else begin
                            r_ang   <= ang_nx;
                            r_rem   <= {1'b0, red_nx};
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_MULA, ST_MULR: begin
                    r_half <= !r_half;
                    if (!r_half) begin
                        r_prod <= mul_p;
                    end else if (r_k == 2'd2) begin
                        // Round the finished dot product back to Q30
                        if (r_state == ST_MULA) begin
                            r_a[idx3(r_row, r_col)] <= rnd30[31:0];
                        end else begin
                            r_rot[idx3(r_row, r_col)] <= rnd30[31:0];
                        end
                        r_acc <= '0;
                        r_k   <= '0;
                        if (r_col == 2'd2) begin
                            r_col <= '0;
                            r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (last_entry) begin
                            r_state <= (r_state == ST_MULA) ? ST_MULR : ST_COEF;
                        end
                    end else begin
                        r_acc <= acc_nx;
                        r_k   <= r_k + 1'b1;
                    end
                end
                ST_COEF: begin
                    r_half <= !r_half;
                    if (!r_half) begin
                        r_prod <= mul_p;
                    end else begin
                        r_coef[idx3(r_row, r_col)] <= sat32(66'(coef_sh));
                        if (r_col == 2'd2) begin
                            r_col <= '0;
                            r_row <= (r_row == 2'd2) ? 2'd0 : r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                        if (last_entry) begin
                            r_ready <= 1'b1;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[design/trs_vxpipe.sv]
// Vertex pipeline: products, rounded row sums, translation and saturation.
module trs_vxpipe import trs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mat         i_mat,
    input  logic [2:0][31:0] i_move,
    input  logic         i_vld,
    input  logic [95:0]  i_data,
    output logic         o_pop,
    output logic         o_tvalid,
    input  logic         i_tready,
    output logic [127:0] o_tdata
);

    logic               r_v1, r_v2, r_v3;
    logic signed [63:0] r_p [9];
    logic signed [65:0] r_s [3];
    logic [2:0][31:0]   r_out;
    logic               en;
    logic signed [65:0] sum [3];

    // Whole pipeline moves when the output register is free or being taken
    assign en       = !r_v3 || i_tready;
    assign o_pop    = en && i_vld && i_mat.ready;
    assign o_tvalid = r_v3;
    assign o_tdata  = {W_ONE, r_out[2], r_out[1], r_out[0]};

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sum[r] = 66'(r_p[3*r]) + 66'(r_p[3*r+1]) + 66'(r_p[3*r+2])
                   + (66'sd1 <<< (FRAC_BITS - 1));
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_p[3*r+c] <= signed'(i_mat.coef[3*r+c]) * signed'(i_data[32*c +: 32]);
                end
                r_s[r]   <= sum[r] >>> FRAC_BITS;
                r_out[r] <= sat32(r_s[r] + 66'(signed'(i_move[r])));
            end
        end
    end

endmodule

[design/trs_vertex_transform.sv]
// Top level: configuration registers, input queue, matrix builder, vertex pipeline.
//
// Transforms Q16.16 vertices by M = T * Rx(pitch) * Ry(yaw) * Rz(roll) * S and returns
// saturated Q16.16 x, y, z with w = 1.0. Once the matrix is built, one vertex is
// accepted and one result delivered per cycle while the output is not stalled; a
// vertex passes from the input queue through the product, row-sum and output registers.
// After reset or any write to a configuration register the matrix is rebuilt by a
// sequencer around one shared CORDIC and one 32x32 multiplier: per angle a phase
// conversion and 30 CORDIC steps, then the two rotation products and the scaling.
// Vertices queue (up to FIFO_DEPTH) meanwhile. Registers sit at byte address 8*i over
// APB; write them only while no vertex is in flight.
module trs_vertex_transform import trs_pkg::*; #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // out_x, out_y, out_z, out_w
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [5:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    output logic [63:0]  o_prdata,
    output logic         o_pready
);

    t_cfg        r_cfg;
    t_reg_idx    reg_idx;
    logic        wr, cfg_wr;
    t_mat        mat;
    logic        q_vld, q_pop;
    logic [95:0] q_data;

    assign o_pready = 1'b1;
    assign reg_idx  = t_reg_idx'(i_paddr[5:3]);
    assign wr       = i_psel && i_penable && i_pwrite;
    assign cfg_wr   = wr && (reg_idx != REG_UNUSED);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move  <= '0;
            r_cfg.angle <= '0;
            r_cfg.scale <= 48'h0100_0100_0100;
        end else if (wr) begin
            unique case (reg_idx)
                REG_MOVE_X: r_cfg.move[0]  <= i_pwdata[31:0];
                REG_MOVE_Y: r_cfg.move[1]  <= i_pwdata[31:0];
                REG_MOVE_Z: r_cfg.move[2]  <= i_pwdata[31:0];
                REG_PITCH:  r_cfg.angle[0] <= i_pwdata[15:0];
                REG_YAW:    r_cfg.angle[1] <= i_pwdata[15:0];
                REG_ROLL:   r_cfg.angle[2] <= i_pwdata[15:0];
                REG_SCALE:  r_cfg.scale    <= i_pwdata[47:0];
                default:    r_cfg          <= r_cfg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_MOVE_X: o_prdata = 64'(r_cfg.move[0]);
            REG_MOVE_Y: o_prdata = 64'(r_cfg.move[1]);
            REG_MOVE_Z: o_prdata = 64'(r_cfg.move[2]);
            REG_PITCH:  o_prdata = 64'(r_cfg.angle[0]);
            REG_YAW:    o_prdata = 64'(r_cfg.angle[1]);
            REG_ROLL:   o_prdata = 64'(r_cfg.angle[2]);
            REG_SCALE:  o_prdata = 64'(r_cfg.scale);
            default:    o_prdata = '0;
        endcase
    end

    trs_infifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_infifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_axis_tvalid),
        .o_tready (o_s_axis_tready),
        .i_tdata  (i_s_axis_tdata),
        .o_vld    (q_vld),
        .o_data   (q_data),
        .i_pop    (q_pop)
    );

    trs_mbuild u_mbuild (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cfg_wr (cfg_wr),
        .o_mat    (mat)
    );

    trs_vxpipe u_vxpipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mat    (mat),
        .i_move   (r_cfg.move),
        .i_vld    (q_vld),
        .i_data   (q_data),
        .o_pop    (q_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata)
    );

endmodule

[design/trs_checker.sv]
// Port-level checks of the vertex transform, bound to the top level.
module trs_checker import trs_pkg::*; (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata,
    input logic         o_pready
);

    // Output channel is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // Every result carries w = 1.0
    a_w_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[127:96] == W_ONE))
        else $error("w is not 1.0");

    // A stalled result holds its data
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) o_pready)
        else $error("pready low");

endmodule

bind trs_vertex_transform trs_checker u_trs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_pready        (o_pready)
);

[tb/sv/trs_checker.sv]
// Scoreboard of the vertex transform: follows the register port, predicts each vertex, compares.
`timescale 1ns / 100ps

module trs_scoreboard import trs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [95:0]  i_s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [127:0] i_m_axis_tdata,   // out_x, out_y, out_z, out_w
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [5:0]   i_paddr,
    input  logic [63:0]  i_pwdata,
    input  logic         i_pready,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
    } t_vtx_out;

    // Arctangent per CORDIC step, 2^32 per turn
    localparam longint ARCTAN_STEP [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
        64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
        64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001
    };

    logic [31:0] move_reg [3];
    logic [15:0] angle_reg [3];
    logic [47:0] scale_reg;
    longint      model_coef [9];
    longint      model_move [3];
    bit          model_valid;
    t_vtx_out    expected_vtx [$];

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Sine and cosine in Q30 of an angle in 1/64 degree
    function automatic void angle_sin_cos(input logic [15:0] ang, output longint s,
                                          output longint c);
        longint a, x, y, nx, p;
        longint unsigned ph;
        bit flip;
        a = longint'(signed'(ang)) % 23040;
        if (a < 0) a += 23040;
        ph = ((longint'(a) << 32) + 11520) / 23040;
        ph &= 64'hFFFF_FFFF;
        p = (ph >= 64'h8000_0000) ? longint'(ph) - 64'sh1_0000_0000 : longint'(ph);
        flip = 1'b0;
        // fold into +-90 degrees
        if (p > 64'sh4000_0000) begin
            p -= 64'sh8000_0000;
            flip = 1'b1;
        end else if (p < -64'sh4000_0000) begin
            p += 64'sh8000_0000;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++) begin
            if (p >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                p -= ARCTAN_STEP[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                p += ARCTAN_STEP[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic void rot_product(input longint a [9], input longint b [9],
                                        output longint o [9]);
        longint acc;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[r*3+k] * b[k*3+c];
                o[r*3+c] = (acc + (64'sd1 << 29)) >>> 30;
            end
        end
    endfunction

    // Build the scaled rotation from the current registers
    function automatic void build_model();
        longint one, sx, cx, sy, cy, sz, cz, sc [3];
        longint rx [9], ry [9], rz [9], t [9], rot [9];
        one = 64'sd1 << 30;
        angle_sin_cos(angle_reg[0], sx, cx);
        angle_sin_cos(angle_reg[1], sy, cy);
        angle_sin_cos(angle_reg[2], sz, cz);
        rx = '{one, 0, 0, 0, cx, -sx, 0, sx, cx};
        ry = '{cy, 0, sy, 0, one, 0, -sy, 0, cy};
        rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, one};
        rot_product(rx, ry, t);
        rot_product(t, rz, rot);
        sc[0] = longint'(signed'(scale_reg[47:32]));
        sc[1] = longint'(signed'(scale_reg[31:16]));
        sc[2] = longint'(signed'(scale_reg[15:0]));
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                model_coef[r*3+c] = clamp32((rot[r*3+c] * sc[c]
                    + (64'sd1 << (COEF_SHIFT - 1))) >>> COEF_SHIFT);
            end
            model_move[r] = longint'(signed'(move_reg[r]));
        end
        model_valid = 1'b1;
    endfunction

    function automatic t_vtx_out transform_vertex(input logic [95:0] d);
        longint v [3], prod, hi, lo, res [3];
        t_vtx_out o;
        for (int c = 0; c < 3; c++) v[c] = longint'(signed'(d[32*c +: 32]));
        for (int r = 0; r < 3; r++) begin
            hi = 0;
            lo = 0;
            for (int c = 0; c < 3; c++) begin
                prod = model_coef[r*3+c] * v[c];
                hi += prod >>> FRAC_BITS;
                lo += prod & ((64'sd1 << FRAC_BITS) - 1);
            end
            res[r] = clamp32(hi + ((lo + (64'sd1 << (FRAC_BITS - 1))) >>> FRAC_BITS)
                             + model_move[r]);
        end
        o.x = res[0][31:0];
        o.y = res[1][31:0];
        o.z = res[2][31:0];
        o.w = W_ONE;
        return o;
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v),
                   $signed(act_v));
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_vtx_out e;
        t_reg_idx idx;
        if (!i_rst_n) begin
            move_reg     = '{32'd0, 32'd0, 32'd0};
            angle_reg    = '{16'd0, 16'd0, 16'd0};
            scale_reg    = 48'h0100_0100_0100;
            model_valid  = 1'b0;
            o_fail_count = 0;
            expected_vtx.delete();
            o_pending    = 0;
        end else begin
            // register write: store and drop the built matrix
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = t_reg_idx'(i_paddr[5:3]);
                case (idx) inside
                    REG_MOVE_X, REG_MOVE_Y, REG_MOVE_Z: begin
                        move_reg[idx] = i_pwdata[31:0];
                        model_valid = 1'b0;
                    end
                    REG_PITCH, REG_YAW, REG_ROLL: begin
                        angle_reg[idx - REG_PITCH] = i_pwdata[15:0];
                        model_valid = 1'b0;
                    end
                    REG_SCALE: begin
                        scale_reg = i_pwdata[47:0];
                        model_valid = 1'b0;
                    end
                    default: ;
                endcase
            end
            // vertex transfer: predict its result
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                if (!model_valid) build_model();
                expected_vtx.push_back(transform_vertex(i_s_axis_tdata));
            end
            // result transfer: check against the oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_vtx.size() == 0) begin
                    $error("unexpected result transfer, tdata %h", i_m_axis_tdata);
                    o_fail_count++;
                end else begin
                    e = expected_vtx.pop_front();
                    compare_field("out_x", e.x, i_m_axis_tdata[31:0]);
                    compare_field("out_y", e.y, i_m_axis_tdata[63:32]);
                    compare_field("out_z", e.z, i_m_axis_tdata[95:64]);
                    compare_field("out_w", e.w, i_m_axis_tdata[127:96]);
                end
            end
            o_pending = expected_vtx.size();
        end
    end

endmodule

[tb/sv/tb_top.sv]
// Testbench top of the vertex transform: stimulus, idling phases and verdict.
`timescale 1ns / 100ps

module tb_top;
    import trs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 20;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [95:0]  i_s_axis_tdata = '0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;
    logic         i_psel = 1'b0;
    logic         i_penable = 1'b0;
    logic         i_pwrite = 1'b0;
    logic [5:0]   i_paddr = '0;
    logic [63:0]  i_pwdata = '0;
    logic [63:0]  o_prdata;
    logic         o_pready;

    int fail_count;
    int pending_results;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;

    trs_vertex_transform dut (.*);

    trs_scoreboard u_checker (
        .i_clk, .i_rst_n,
        .i_s_axis_tvalid, .i_s_axis_tready(o_s_axis_tready), .i_s_axis_tdata,
        .i_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready, .i_m_axis_tdata(o_m_axis_tdata),
        .i_psel, .i_penable, .i_pwrite, .i_paddr, .i_pwdata, .i_pready(o_pready),
        .o_fail_count(fail_count), .o_pending(pending_results)
    );

    always #5 i_clk = ~i_clk;

    // Randomly stall the result side
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("trs_vertex_transform regression: fail");
            $finish;
        end
    end

    task automatic reg_write(input t_reg_idx idx, input logic [63:0] value);
        @(negedge i_clk);
        i_psel    = 1'b1;
        i_penable = 1'b0;
        i_pwrite  = 1'b1;
        i_paddr   = {idx, 3'b000};
        i_pwdata  = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        @(negedge i_clk);
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
    endtask

    task automatic send_vertex(input logic [31:0] vx, input logic [31:0] vy,
                               input logic [31:0] vz);
        // hold off at random, then present until the transfer happens
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {vz, vy, vx};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every result has come back
    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        wait (pending_results == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h10_0000;
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom) >>> $urandom_range(4, 14));
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 46080)) - 16'd23040;
    endfunction

    function automatic logic [15:0] rand_scale();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 1024)) - 16'd512;
            default: return 16'($urandom_range(0, 256)) - 16'd128;
        endcase
    endfunction

    task automatic random_setup();
        reg_write(REG_MOVE_X, 64'($signed(rand_coord())));
        reg_write(REG_MOVE_Y, 64'($urandom));
        reg_write(REG_MOVE_Z, 64'($signed(rand_coord())));
        reg_write(REG_PITCH, 64'(rand_angle()));
        reg_write(REG_YAW, 64'(rand_angle()));
        reg_write(REG_ROLL, 64'(rand_angle()));
        reg_write(REG_SCALE, {$urandom, $urandom});
        reg_write(REG_SCALE, {16'd0, rand_scale(), rand_scale(), rand_scale()});
    endtask

    task automatic random_vertices(input int count);
        for (int n = 0; n < count; n++) begin
            send_vertex(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity after reset: extremes of each field pass through
        send_vertex(32'd0, 32'd0, 32'd0);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        drain();

        // translation saturates, write beyond the register list is ignored
        reg_write(REG_MOVE_X, 64'h7FFF_FFFF);
        reg_write(REG_MOVE_Y, 64'hFFFF_FFFF_8000_0000);
        reg_write(REG_MOVE_Z, 64'h0003_0000);
        reg_write(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
        send_vertex(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        drain();

        // quarter and half turns, full turns at both limits, angles outside one turn
        reg_write(REG_MOVE_X, 64'd0);
        reg_write(REG_MOVE_Y, 64'd0);
        reg_write(REG_MOVE_Z, 64'd0);
        reg_write(REG_PITCH, 64'd5760);
        reg_write(REG_YAW, 64'(-16'sd11520));
        reg_write(REG_ROLL, 64'd23040);
        send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        reg_write(REG_PITCH, 64'h8000);
        reg_write(REG_YAW, 64'h7FFF);
        reg_write(REG_ROLL, 64'(-16'sd23040));
        reg_write(REG_SCALE, 64'h7FFF_8000_0000);
        send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_4000);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();
        reg_write(REG_SCALE, 64'hFF00_0080_7FFF);
        reg_write(REG_PITCH, 64'd11520);
        send_vertex(32'h0005_0000, 32'h7FFF_FFFF, 32'hFFFB_0000);
        send_vertex(32'h1234_5678, 32'h8765_4321, 32'hDEAD_BEEF);
        drain();

        // random phases: no idling, sender idle, receiver stall, both
        random_setup();
        src_idle_pct = 0;  sink_stall_pct = 0;
        random_vertices(100);
        drain();
        random_vertices(90);
        drain();
        random_setup();
        src_idle_pct = 73; sink_stall_pct = 0;
        random_vertices(185);
        drain();
        random_setup();
        src_idle_pct = 0;  sink_stall_pct = 73;
        random_vertices(185);
        drain();
        random_setup();
        src_idle_pct = 37; sink_stall_pct = 37;
        random_vertices(185);
        drain();

        if (fail_count == 0) begin
            $display("trs_vertex_transform regression: pass");
        end else begin
            $display("trs_vertex_transform regression: fail");
        end
        $finish;
    end

endmodule
